// ===== sv/rss_pkg.sv =====
package rss_pkg;

   // Field widths
   localparam int SAMPLE_BITS    = 16;
   localparam int COUNT_BITS     = 24;
   localparam int MEAN_FRAC_BITS = 16;
   localparam int MEAN_BITS      = SAMPLE_BITS + MEAN_FRAC_BITS;
   localparam int DEV_BITS       = 62;
   localparam int VAR_BITS       = 40;

   // Deviation product scaling back to 8 fraction bits
   localparam int DEV_SHIFT  = 2 * MEAN_FRAC_BITS - 8;
   localparam int PROD_BITS  = 2 * MEAN_BITS;
   localparam int TERM_BITS  = PROD_BITS - DEV_SHIFT;
   localparam int VAR_HI_BITS = DEV_BITS - VAR_BITS;

   // Shared divider sizing
   localparam int DIV_BITS  = (MEAN_BITS > VAR_BITS) ? MEAN_BITS : VAR_BITS;
   localparam int STEP_BITS = $clog2(DIV_BITS + 1);

   // Stream packing
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS = 1;
   localparam int RSP_FIELD_BITS = COUNT_BITS + MEAN_BITS + 2 * SAMPLE_BITS + VAR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   // Request kinds carried on req_tuser
   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_CLEAR      = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic clear_stats;
      logic mark_full;
      logic mean_start;
      logic mean_update;
      logic diff_capture;
      logic prod_capture;
      logic acc_update;
      logic var_start;
      logic var_saturate;
      logic var_update;
      logic load_out;
   } rss_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic is_full;
      logic div_done;
      logic var_needed;
      logic var_sat;
   } rss_status_type;

endpackage

// ===== sv/rss_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// The remainder is preloaded (must be below the divisor) and the dividend
// is left-aligned so that a run of fewer than DIV_BITS steps is allowed.
module rss_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rss_pkg::STEP_BITS-1:0]    steps,
   input  logic [rss_pkg::COUNT_BITS-1:0]   divisor,
   input  logic [rss_pkg::COUNT_BITS-1:0]   rem_init,
   input  logic [rss_pkg::DIV_BITS-1:0]     dividend,
   output logic                             done,
   output logic [rss_pkg::DIV_BITS-1:0]     quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [rss_pkg::STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic [rss_pkg::COUNT_BITS-1:0]   div_ff, div_in;
   logic [rss_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [rss_pkg::DIV_BITS-1:0]     num_ff, num_in;
   logic [rss_pkg::DIV_BITS-1:0]     quo_ff, quo_in;
   logic [rss_pkg::COUNT_BITS:0]     trial;
   logic [rss_pkg::COUNT_BITS:0]     diff;
   logic                             take;

   // One trial subtraction
   always_comb begin
      trial = {rem_ff, num_ff[rss_pkg::DIV_BITS-1]};
      diff  = trial - {1'b0, div_ff};
      take  = (trial >= {1'b0, div_ff});
   end

   // Next state
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         div_in  = divisor;
         rem_in  = rem_init;
         num_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = take ? diff[rss_pkg::COUNT_BITS-1:0] : trial[rss_pkg::COUNT_BITS-1:0];
         num_in = num_ff << 1;
         quo_in = {quo_ff[rss_pkg::DIV_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rss_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operands
   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/rss_datapath.sv =====
// Statistics registers, Welford update arithmetic and the result register.
module rss_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rss_pkg::rss_cmd_type                cmd,
   output rss_pkg::rss_status_type             status,
   input  logic [rss_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [rss_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic [rss_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [rss_pkg::RSP_USER_BITS-1:0]   rsp_tuser
);

   localparam int MB = rss_pkg::MEAN_BITS;

   // Latched request
   logic                                  clear_ff, clear_in;
   logic signed [rss_pkg::SAMPLE_BITS-1:0] sample_ff, sample_in;

   // Statistics
   logic [rss_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [MB-1:0]                  mean_ff, mean_in;
   logic [rss_pkg::DEV_BITS-1:0]          dev_ff, dev_in;
   logic signed [rss_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [rss_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic [rss_pkg::VAR_BITS-1:0]          var_ff, var_in;
   logic                                  var_ok_ff, var_ok_in;
   logic                                  full_ff, full_in;

   // Working values
   logic                                  dneg_ff, dneg_in;
   logic [MB-1:0]                         dmag_ff, dmag_in;
   logic [MB-1:0]                         emag_ff, emag_in;
   logic [rss_pkg::PROD_BITS-1:0]         prod_ff, prod_in;

   // Result register
   logic [rss_pkg::RSP_DATA_BITS-1:0]     rdata_ff, rdata_in;
   logic [rss_pkg::RSP_USER_BITS-1:0]     ruser_ff, ruser_in;

   logic [MB-1:0]                         q;
   logic [MB:0]                           d, d_neg;
   logic [MB-1:0]                         dmag;
   logic [MB:0]                           e, e_neg;
   logic [MB-1:0]                         emag;
   logic [MB-1:0]                         step;
   logic [rss_pkg::COUNT_BITS-1:0]        n_next;
   logic [rss_pkg::COUNT_BITS-1:0]        n_less;
   logic [rss_pkg::VAR_HI_BITS-1:0]       dev_hi;
   logic [rss_pkg::TERM_BITS-1:0]         term;
   logic [rss_pkg::DEV_BITS:0]            dev_sum;

   logic                                  div_start;
   logic [rss_pkg::STEP_BITS-1:0]         div_steps;
   logic [rss_pkg::COUNT_BITS-1:0]        div_divisor;
   logic [rss_pkg::COUNT_BITS-1:0]        div_rem;
   logic [rss_pkg::DIV_BITS-1:0]          div_dividend;
   logic                                  div_done;
   logic [rss_pkg::DIV_BITS-1:0]          div_quotient;

   // Sample scaled to the mean format and its distance to the mean
   always_comb begin
      q     = {sample_ff, {rss_pkg::MEAN_FRAC_BITS{1'b0}}};
      d     = {q[MB-1], q} - {mean_ff[MB-1], mean_ff};
      d_neg = -d;
      dmag  = d[MB] ? d_neg[MB-1:0] : d[MB-1:0];
      e     = {q[MB-1], q} - {mean_ff[MB-1], mean_ff};
      e_neg = -e;
      emag  = e[MB] ? e_neg[MB-1:0] : e[MB-1:0];
   end

   // Counts, deviation term and variance overflow check
   always_comb begin
      n_next  = count_ff + 1'b1;
      n_less  = count_ff - 1'b1;
      dev_hi  = dev_ff[rss_pkg::DEV_BITS-1:rss_pkg::VAR_BITS];
      step    = div_quotient[MB-1:0];
      term    = prod_ff[rss_pkg::PROD_BITS-1:rss_pkg::DEV_SHIFT];
      dev_sum = {1'b0, dev_ff} + (rss_pkg::DEV_BITS + 1)'(term);
   end

   // Shared divider operands: mean step or variance
   always_comb begin
      div_start = cmd.mean_start | cmd.var_start;
      if (cmd.var_start) begin
         div_steps    = rss_pkg::STEP_BITS'(rss_pkg::VAR_BITS);
         div_divisor  = n_less;
         div_rem      = rss_pkg::COUNT_BITS'(dev_hi);
         div_dividend = rss_pkg::DIV_BITS'(dev_ff[rss_pkg::VAR_BITS-1:0])
                        << (rss_pkg::DIV_BITS - rss_pkg::VAR_BITS);
      end else begin
         div_steps    = rss_pkg::STEP_BITS'(MB);
         div_divisor  = n_next;
         div_rem      = '0;
         div_dividend = rss_pkg::DIV_BITS'(dmag) << (rss_pkg::DIV_BITS - MB);
      end
   end

   rss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .divisor  (div_divisor),
      .rem_init (div_rem),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Next values of all registers
   always_comb begin
      clear_in  = clear_ff;
      sample_in = sample_ff;
      count_in  = count_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      var_in    = var_ff;
      var_ok_in = var_ok_ff;
      full_in   = full_ff;
      dneg_in   = dneg_ff;
      dmag_in   = dmag_ff;
      emag_in   = emag_ff;
      prod_in   = prod_ff;
      rdata_in  = rdata_ff;
      ruser_in  = ruser_ff;

      if (cmd.load_item) begin
         clear_in  = (req_tuser[0] == rss_pkg::CMD_CLEAR);
         sample_in = req_tdata[rss_pkg::SAMPLE_BITS-1:0];
         full_in   = 1'b0;
      end
      if (cmd.clear_stats) begin
         count_in  = '0;
         mean_in   = '0;
         dev_in    = '0;
         min_in    = {1'b0, {(rss_pkg::SAMPLE_BITS-1){1'b1}}};
         max_in    = {1'b1, {(rss_pkg::SAMPLE_BITS-1){1'b0}}};
         var_in    = '0;
         var_ok_in = 1'b0;
      end
      if (cmd.mark_full) begin
         full_in = 1'b1;
      end
      if (cmd.mean_start) begin
         dneg_in = d[MB];
         dmag_in = dmag;
      end
      // Mean step, count and extremes
      if (cmd.mean_update) begin
         mean_in  = dneg_ff ? (mean_ff - $signed(step)) : (mean_ff + $signed(step));
         count_in = n_next;
         if (sample_ff > max_ff) begin
            max_in = sample_ff;
         end
         if (sample_ff < min_ff) begin
            min_in = sample_ff;
         end
      end
      if (cmd.diff_capture) begin
         emag_in = emag;
      end
      if (cmd.prod_capture) begin
         prod_in = dmag_ff * emag_ff;
      end
      // Saturating deviation sum
      if (cmd.acc_update) begin
         dev_in = dev_sum[rss_pkg::DEV_BITS] ? '1 : dev_sum[rss_pkg::DEV_BITS-1:0];
      end
      if (cmd.var_saturate) begin
         var_in    = '1;
         var_ok_in = 1'b1;
      end
      if (cmd.var_update) begin
         var_in    = div_quotient[rss_pkg::VAR_BITS-1:0];
         var_ok_in = 1'b1;
      end
      // Fields from the lowest bit: count, mean, minimum, maximum, variance
      if (cmd.load_out) begin
         rdata_in = rss_pkg::RSP_DATA_BITS'({var_ok_ff ? var_ff : '0, max_ff, min_ff,
                                             mean_ff, count_ff});
         ruser_in = {full_ff, var_ok_ff};
      end
   end

   // Statistics are architectural state and reset with the block
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         mean_ff   <= '0;
         dev_ff    <= '0;
         min_ff    <= {1'b0, {(rss_pkg::SAMPLE_BITS-1){1'b1}}};
         max_ff    <= {1'b1, {(rss_pkg::SAMPLE_BITS-1){1'b0}}};
         var_ff    <= '0;
         var_ok_ff <= 1'b0;
         full_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         mean_ff   <= mean_in;
         dev_ff    <= dev_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         var_ff    <= var_in;
         var_ok_ff <= var_ok_in;
         full_ff   <= full_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      clear_ff  <= clear_in;
      sample_ff <= sample_in;
      dneg_ff   <= dneg_in;
      dmag_ff   <= dmag_in;
      emag_ff   <= emag_in;
      prod_ff   <= prod_in;
      rdata_ff  <= rdata_in;
      ruser_ff  <= ruser_in;
   end

   // Status to the controller
   always_comb begin
      status.is_clear   = clear_ff;
      status.is_full    = (count_ff == '1);
      status.div_done   = div_done;
      status.var_needed = (count_ff >= rss_pkg::COUNT_BITS'(2));
      status.var_sat    = (rss_pkg::DEV_BITS'(dev_hi) >= rss_pkg::DEV_BITS'(n_less));
   end

   assign rsp_tdata = rdata_ff;
   assign rsp_tuser = ruser_ff;

endmodule

// ===== sv/rss_ctrl.sv =====
// Sequencer for one request: dispatch, mean division, deviation product,
// accumulate, variance division and hand-off to the result register.
module rss_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  rss_pkg::rss_status_type  status,
   output rss_pkg::rss_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MEAN,
      ST_DIFF,
      ST_PROD,
      ST_ACC,
      ST_VAR,
      ST_VAR_WAIT,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_clear) begin
               cmd.clear_stats = 1'b1;
               state_in        = ST_REPORT;
            end else if (status.is_full) begin
               cmd.mark_full = 1'b1;
               state_in      = ST_REPORT;
            end else begin
               cmd.mean_start = 1'b1;
               state_in       = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (status.div_done) begin
               cmd.mean_update = 1'b1;
               state_in        = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff_capture = 1'b1;
            state_in         = ST_PROD;
         end
         ST_PROD: begin
            cmd.prod_capture = 1'b1;
            state_in         = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_update = 1'b1;
            state_in       = ST_VAR;
         end
         // Variance only from two samples on; quotient overflow caught up front
         ST_VAR: begin
            if (!status.var_needed) begin
               state_in = ST_REPORT;
            end else if (status.var_sat) begin
               cmd.var_saturate = 1'b1;
               state_in         = ST_REPORT;
            end else begin
               cmd.var_start = 1'b1;
               state_in      = ST_VAR_WAIT;
            end
         end
         ST_VAR_WAIT: begin
            if (status.div_done) begin
               cmd.var_update = 1'b1;
               state_in       = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/running_sample_statistics.sv =====
// An accumulated sample runs the mean division (32 divider steps) and then the variance
// division (40 steps) on one shared divider before it reaches the result register; the
// variance division is skipped below two samples or when its quotient would overflow.
// A clear or a dropped sample goes straight to the result register. Requests are taken
// one at a time; the next request is taken while a result waits on rsp_tready.
// Reset (synchronous): empty statistics, minimum at most positive, maximum at most negative.
module running_sample_statistics (
   input  logic                                clock,
   input  logic                                reset,
   // Request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rss_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // [15:0] sample
   input  logic [rss_pkg::REQ_USER_BITS-1:0]   req_tuser,  // [0] cmd (1 = clear)
   // Result
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rss_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // count, mean, minimum, maximum,
                                                           // variance
   output logic [rss_pkg::RSP_USER_BITS-1:0]   rsp_tuser   // [0] variance_valid,
                                                           // [1] count_full
);

   rss_pkg::rss_cmd_type    cmd;
   rss_pkg::rss_status_type status;

   rss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ===== bench/running_stats_checker.sv =====
// Watches both stream channels of running_sample_statistics, keeps its own
// copy of the statistics and checks every result against it.
module running_stats_checker (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   input  logic                                       req_tready,
   input  logic [rss_pkg::REQ_DATA_BITS-1:0]          req_tdata,  // [15:0] sample
   input  logic [rss_pkg::REQ_USER_BITS-1:0]          req_tuser,  // [0] cmd
   input  logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   input  logic [rss_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,  // count, mean, minimum,
                                                                  // maximum, variance
   input  logic [rss_pkg::RSP_USER_BITS-1:0]          rsp_tuser,  // [0] variance_valid,
                                                                  // [1] count_full
   output int                                         fail_count,
   output int                                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        [rss_pkg::COUNT_BITS-1:0]  count;
      logic signed [rss_pkg::MEAN_BITS-1:0]   mean;
      logic signed [rss_pkg::SAMPLE_BITS-1:0] minimum;
      logic signed [rss_pkg::SAMPLE_BITS-1:0] maximum;
      logic        [rss_pkg::VAR_BITS-1:0]    variance;
      logic                                   variance_valid;
      logic                                   count_full;
   } stats_result_type;

   // Field offsets within rsp_tdata
   localparam int MEAN_LSB = rss_pkg::COUNT_BITS;
   localparam int MIN_LSB  = MEAN_LSB + rss_pkg::MEAN_BITS;
   localparam int MAX_LSB  = MIN_LSB + rss_pkg::SAMPLE_BITS;
   localparam int VAR_LSB  = MAX_LSB + rss_pkg::SAMPLE_BITS;

   localparam logic [rss_pkg::COUNT_BITS-1:0] COUNT_LIMIT = '1;
   localparam bit [63:0] DEV_LIMIT = (64'd1 << rss_pkg::DEV_BITS) - 64'd1;
   localparam bit [63:0] VAR_LIMIT = (64'd1 << rss_pkg::VAR_BITS) - 64'd1;

   // Shadow statistics
   bit [rss_pkg::COUNT_BITS-1:0]           stat_count;
   longint                                 stat_mean;
   bit [63:0]                              stat_devsum;
   logic signed [rss_pkg::SAMPLE_BITS-1:0] stat_min;
   logic signed [rss_pkg::SAMPLE_BITS-1:0] stat_max;
   bit [rss_pkg::VAR_BITS-1:0]             stat_var;
   bit                                     stat_var_ok;

   stats_result_type expected_stats[$];

   function automatic void clear_stats();
      stat_count  = '0;
      stat_mean   = 0;
      stat_devsum = '0;
      stat_min    = {1'b0, {(rss_pkg::SAMPLE_BITS-1){1'b1}}};
      stat_max    = {1'b1, {(rss_pkg::SAMPLE_BITS-1){1'b0}}};
      stat_var    = '0;
      stat_var_ok = 1'b0;
   endfunction

   // One Welford step: mean moves by d/N, deviation sum grows by d*(q - new mean)
   function automatic void take_sample(logic signed [rss_pkg::SAMPLE_BITS-1:0] x);
      longint     q, d, e;
      bit [63:0]  n, dmag, emag, step, term, quot;
      bit [127:0] prod;
      stat_count = stat_count + 1'b1;
      n    = 64'(stat_count);
      q    = longint'(x) * (longint'(1) << rss_pkg::MEAN_FRAC_BITS);
      d    = q - stat_mean;
      dmag = (d < 0) ? 64'(-d) : 64'(d);
      step = dmag / n;
      stat_mean = (d < 0) ? stat_mean - longint'(step) : stat_mean + longint'(step);
      e    = q - stat_mean;
      emag = (e < 0) ? 64'(-e) : 64'(e);
      prod = {64'd0, dmag} * {64'd0, emag};
      prod = prod >> rss_pkg::DEV_SHIFT;
      term = (prod > {64'd0, DEV_LIMIT}) ? DEV_LIMIT : prod[63:0];
      // saturating accumulate
      stat_devsum = (term > DEV_LIMIT - stat_devsum) ? DEV_LIMIT : stat_devsum + term;
      if (x > stat_max) stat_max = x;
      if (x < stat_min) stat_min = x;
      if (n >= 64'd2) begin
         quot        = stat_devsum / (n - 64'd1);
         stat_var    = (quot > VAR_LIMIT) ? VAR_LIMIT[rss_pkg::VAR_BITS-1:0]
                                          : quot[rss_pkg::VAR_BITS-1:0];
         stat_var_ok = 1'b1;
      end
   endfunction

   function automatic stats_result_type predict_stats(
         logic cmd, logic signed [rss_pkg::SAMPLE_BITS-1:0] x);
      stats_result_type res;
      res.count_full = 1'b0;
      if (cmd == rss_pkg::CMD_CLEAR) begin
         clear_stats();
      end else if (stat_count == COUNT_LIMIT) begin
         // saturated count: sample dropped
         res.count_full = 1'b1;
      end else begin
         take_sample(x);
      end
      res.count          = stat_count;
      res.mean           = stat_mean[rss_pkg::MEAN_BITS-1:0];
      res.minimum        = stat_min;
      res.maximum        = stat_max;
      res.variance       = stat_var_ok ? stat_var : '0;
      res.variance_valid = stat_var_ok;
      return res;
   endfunction

   task automatic check_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Results are taken before requests: a request never answers in its own cycle
   always @(posedge clock) begin
      stats_result_type want, got;
      if (reset) begin
         clear_stats();
         expected_stats.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.count          = rsp_tdata[rss_pkg::COUNT_BITS-1:0];
            got.mean           = rsp_tdata[MEAN_LSB +: rss_pkg::MEAN_BITS];
            got.minimum        = rsp_tdata[MIN_LSB +: rss_pkg::SAMPLE_BITS];
            got.maximum        = rsp_tdata[MAX_LSB +: rss_pkg::SAMPLE_BITS];
            got.variance       = rsp_tdata[VAR_LSB +: rss_pkg::VAR_BITS];
            got.variance_valid = rsp_tuser[0];
            got.count_full     = rsp_tuser[1];
            if (expected_stats.size() == 0) begin
               $error("result arrived with no request outstanding");
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               check_field("count", want.count, got.count);
               check_field("mean", want.mean, got.mean);
               check_field("minimum", want.minimum, got.minimum);
               check_field("maximum", want.maximum, got.maximum);
               check_field("variance", want.variance, got.variance);
               check_field("variance_valid", want.variance_valid, got.variance_valid);
               check_field("count_full", want.count_full, got.count_full);
            end
         end
         if (req_tvalid && req_tready)
            expected_stats.push_back(
               predict_stats(req_tuser[0], $signed(req_tdata[rss_pkg::SAMPLE_BITS-1:0])));
      end
      outstanding = expected_stats.size();
   end

endmodule

// ===== bench/running_sample_statistics_tb.sv =====
module running_sample_statistics_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS     = 115;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [rss_pkg::REQ_DATA_BITS-1:0]  req_tdata;   // [15:0] sample
   logic [rss_pkg::REQ_USER_BITS-1:0]  req_tuser;   // [0] cmd
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [rss_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;   // count, mean, minimum, maximum, variance
   logic [rss_pkg::RSP_USER_BITS-1:0]  rsp_tuser;   // [0] variance_valid, [1] count_full

   int fail_count;
   int outstanding;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   bit hold_rsp        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   running_sample_statistics uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   running_stats_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Result side back-pressure, with one long hold-off on demand
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one request, returning at the edge where it is taken
   task automatic put_request(input logic cmd,
                              input logic [rss_pkg::SAMPLE_BITS-1:0] sample);
      bit ready_seen;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tuser  <= cmd;
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   function automatic logic [rss_pkg::SAMPLE_BITS-1:0] pick_sample(
         int style, logic [rss_pkg::SAMPLE_BITS-1:0] centre);
      case (style)
         0: return rss_pkg::SAMPLE_BITS'($urandom);
         1: return centre + rss_pkg::SAMPLE_BITS'($urandom_range(63)) - 16'd32;
         2: return centre;
         3: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return rss_pkg::SAMPLE_BITS'($urandom_range(15)) - 16'd8;
      endcase
   endfunction

   initial begin
      int                              phase_items, run_len, style;
      logic [rss_pkg::SAMPLE_BITS-1:0] centre;
      bit                              hold_done;
      hold_done  = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = rss_pkg::CMD_ACCUMULATE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty state, extremes, single sample, repeated clears, flat data
      put_request(rss_pkg::CMD_CLEAR, 16'h5A5A);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h7FFF);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h8000);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h0000);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'hFFFF);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h0001);
      put_request(rss_pkg::CMD_CLEAR, 16'h8000);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h8000);
      put_request(rss_pkg::CMD_CLEAR, 16'hFFFF);
      put_request(rss_pkg::CMD_CLEAR, 16'h7FFF);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'd1234);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'd1234);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'd1234);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'd1234);
      put_request(rss_pkg::CMD_CLEAR, 16'h0000);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h7FFF);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h7FFF);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h8000);
      put_request(rss_pkg::CMD_ACCUMULATE, 16'h8000);
      drain_results();

      // Random runs under four idling regimes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin sender_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            // long result hold-off while requests keep coming
            if (phase == 0 && phase_items > 20 && !hold_done) begin
               hold_rsp  = 1'b1;
               hold_done = 1'b1;
            end
            // most runs start fresh; some keep growing the count
            if ($urandom_range(3) != 0) begin
               put_request(rss_pkg::CMD_CLEAR, rss_pkg::SAMPLE_BITS'($urandom));
               phase_items++;
            end
            run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
            style   = $urandom_range(4);
            centre  = rss_pkg::SAMPLE_BITS'($urandom);
            repeat (run_len) begin
               put_request(rss_pkg::CMD_ACCUMULATE, pick_sample(style, centre));
               phase_items++;
            end
         end
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
